[hw/rtl/wse_pkg.sv]
// ----------------------------------------------------------------------------
// wse_pkg: shared types and constants of the WAV stream sample extractor
// Holds the chunk tags, the run status codes and the step result record
// that the parser hands to the result register.
// ----------------------------------------------------------------------------
package wse_pkg;

	// Chunk and header tags, first file byte in the top byte
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	// Run status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_RIFF   = 3'd1;
	localparam logic [2:0] ST_BAD_WAVE   = 3'd2;
	localparam logic [2:0] ST_NO_FMT     = 3'd3;
	localparam logic [2:0] ST_BAD_DEPTH  = 3'd4;
	localparam logic [2:0] ST_NO_DATA    = 3'd5;
	localparam logic [2:0] ST_ZERO_CHANS = 3'd6;
	localparam logic [2:0] ST_TRUNCATED  = 3'd7;

	// One result request
	typedef struct packed {
		logic        sample_valid;
		logic [31:0] sample_value;
		logic        sample_is_float;
		logic        run_done;
		logic [2:0]  status;
	} step_res_t;

endpackage

[hw/rtl/wse_parser.sv]
// ----------------------------------------------------------------------------
// wse_parser: byte register and RIFF/WAVE chunk walker
// Registers each accepted byte, then in one pass updates the parse state and
// forms the result request (sample and/or end of run) for that byte.
// ----------------------------------------------------------------------------
module wse_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  logic [7:0]          in_byte,
	input  logic                end_of_file,
	input  logic                res_ready,
	output logic                res_load,
	output wse_pkg::step_res_t  res
);
	import wse_pkg::*;

	typedef enum logic [2:0] {
		PH_RIFF, PH_SIZE, PH_WAVE, PH_HEAD, PH_FMT, PH_SKIP, PH_DATA, PH_DONE
	} phase_t;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;

	// parse state
	phase_t      phase_q,  phase_d;
	logic [3:0]  fcnt_q,   fcnt_d;
	logic [31:0] brem_q,   brem_d;
	logic [31:0] tag_q,    tag_d;
	logic [31:0] clen_q,   clen_d;
	logic        fmt_q,    fmt_d;
	logic [15:0] chans_q,  chans_d;
	logic [15:0] bits_q,   bits_d;
	logic [17:0] fpos_q,   fpos_d;
	logic [31:0] asm_q,    asm_d;

	logic        step;
	logic        accept;
	logic [3:0]  fcnt_inc;
	logic [31:0] brem_dec;
	logic [31:0] fmt_off;
	logic [2:0]  sbytes;
	logic [17:0] fbytes;
	logic [17:0] fbytes_rest;
	logic [17:0] fpos_inc;
	logic        depth_ok;
	logic        s_valid;
	logic [31:0] s_value;
	logic        s_float;
	logic        done;
	logic [2:0]  stat;

	// a byte is processed when the result register can take its request
	assign step       = valid_s1 && res_ready;
	assign byte_stall = valid_s1 && !res_ready;
	assign accept     = byte_valid && !byte_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			eof_s1  <= end_of_file;
		end
	end

	// shared arithmetic
	assign fcnt_inc    = fcnt_q + 4'd1;
	assign brem_dec    = brem_q - 32'd1;
	assign fmt_off     = clen_q - brem_q;
	assign sbytes      = bits_q[5:3];
	assign fbytes      = {2'b00, chans_q} * {15'd0, sbytes};
	assign fbytes_rest = fbytes - {15'd0, sbytes};
	assign fpos_inc    = fpos_q + 18'd1;
	assign depth_ok    = (bits_q == 16'd16) || (bits_q == 16'd24) || (bits_q == 16'd32);

	// next state and result for the byte in the input register
	always_comb begin
		phase_d = phase_q;
		fcnt_d  = fcnt_q;
		brem_d  = brem_q;
		tag_d   = tag_q;
		clen_d  = clen_q;
		fmt_d   = fmt_q;
		chans_d = chans_q;
		bits_d  = bits_q;
		fpos_d  = fpos_q;
		asm_d   = asm_q;
		s_valid = 1'b0;
		s_value = 32'd0;
		s_float = 1'b0;
		done    = 1'b0;
		stat    = ST_OK;

		unique case (phase_q)
			PH_RIFF, PH_WAVE: begin
				tag_d  = {tag_q[23:0], byte_s1};
				fcnt_d = fcnt_inc;
				if (fcnt_inc == 4'd4) begin
					fcnt_d = 4'd0;
					if (phase_q == PH_RIFF) begin
						if (tag_d == TAG_RIFF) begin
							phase_d = PH_SIZE;
						end else begin
							phase_d = PH_DONE;
							done    = 1'b1;
							stat    = ST_BAD_RIFF;
						end
					end else begin
						if (tag_d == TAG_WAVE) begin
							phase_d = PH_HEAD;
						end else begin
							phase_d = PH_DONE;
							done    = 1'b1;
							stat    = ST_BAD_WAVE;
						end
					end
				end
			end
			PH_SIZE: begin
				fcnt_d = fcnt_inc;
				if (fcnt_inc == 4'd4) begin
					fcnt_d  = 4'd0;
					phase_d = PH_WAVE;
				end
			end
			PH_HEAD: begin
				if (fcnt_q < 4'd4) begin
					tag_d = {tag_q[23:0], byte_s1};
				end else begin
					clen_d = {byte_s1, clen_q[31:8]};
				end
				fcnt_d = fcnt_inc;
				// header complete: dispatch on the tag
				if (fcnt_inc == 4'd8) begin
					fcnt_d = 4'd0;
					if (tag_d == TAG_FMT) begin
						fmt_d   = 1'b1;
						brem_d  = clen_d;
						phase_d = (clen_d == 32'd0) ? PH_HEAD : PH_FMT;
					end else if (tag_d == TAG_DATA) begin
						if (!fmt_q) begin
							phase_d = PH_DONE;
							done    = 1'b1;
							stat    = ST_NO_FMT;
						end else if (!depth_ok) begin
							phase_d = PH_DONE;
							done    = 1'b1;
							stat    = ST_BAD_DEPTH;
						end else if (chans_q == 16'd0) begin
							phase_d = PH_DONE;
							done    = 1'b1;
							stat    = ST_ZERO_CHANS;
						end else begin
							brem_d = clen_d;
							fpos_d = 18'd0;
							asm_d  = 32'd0;
							if (clen_d == 32'd0) begin
								phase_d = PH_DONE;
								done    = 1'b1;
								stat    = ST_OK;
							end else begin
								phase_d = PH_DATA;
							end
						end
					end else begin
						brem_d  = clen_d;
						fcnt_d  = {3'd0, clen_d[0]};
						phase_d = (clen_d == 32'd0) ? PH_HEAD : PH_SKIP;
					end
				end
			end
			PH_FMT: begin
				tag_d = {byte_s1, tag_q[31:8]};
				if (fmt_off == 32'd3) begin
					chans_d = tag_d[31:16];
				end else if (fmt_off == 32'd15) begin
					bits_d = tag_d[31:16];
				end
				brem_d = brem_dec;
				if (fmt_off >= 32'd15 && brem_q > 32'd1) begin
					// rest of the chunk is skipped
					fcnt_d  = {3'd0, clen_q[0]};
					phase_d = PH_SKIP;
				end else if (brem_dec == 32'd0) begin
					fcnt_d  = {3'd0, clen_q[0]};
					phase_d = clen_q[0] ? PH_SKIP : PH_HEAD;
				end
			end
			PH_SKIP: begin
				if (brem_q != 32'd0) begin
					brem_d = brem_dec;
				end else begin
					fcnt_d = 4'd0;
				end
				if (brem_d == 32'd0 && fcnt_d == 4'd0) begin
					phase_d = PH_HEAD;
				end
			end
			PH_DATA: begin
				brem_d = brem_dec;
				if (fpos_q < {15'd0, sbytes}) begin
					asm_d = {byte_s1, asm_q[31:8]};
					// last byte of channel 0, whole frame still ahead
					if (fpos_q == {15'd0, sbytes} - 18'd1 &&
					    brem_dec >= {14'd0, fbytes_rest}) begin
						s_valid = 1'b1;
						case (sbytes)
							3'd4: begin
								s_value = asm_d;
								s_float = 1'b1;
							end
							3'd2:    s_value = {{8{asm_d[31]}}, asm_d[31:16], 8'h00};
							default: s_value = {{8{asm_d[31]}}, asm_d[31:8]};
						endcase
					end
				end
				fpos_d = (fpos_inc >= fbytes) ? 18'd0 : fpos_inc;
				if (brem_dec == 32'd0) begin
					phase_d = PH_DONE;
					done    = 1'b1;
					stat    = ST_OK;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		// final byte: close an open run, then rearm
		if (eof_s1) begin
			if (!done && phase_q != PH_DONE) begin
				done = 1'b1;
				if (phase_d == PH_RIFF || phase_d == PH_SIZE) begin
					stat = ST_BAD_RIFF;
				end else if (phase_d == PH_WAVE) begin
					stat = ST_BAD_WAVE;
				end else if (phase_d == PH_DATA) begin
					stat = ST_TRUNCATED;
				end else begin
					stat = ST_NO_DATA;
				end
			end
			phase_d = PH_RIFF;
			fcnt_d  = 4'd0;
			brem_d  = 32'd0;
			tag_d   = 32'd0;
			clen_d  = 32'd0;
			fmt_d   = 1'b0;
			chans_d = 16'd1;
			bits_d  = 16'd16;
			fpos_d  = 18'd0;
			asm_d   = 32'd0;
		end
	end

	// result request
	always_comb begin
		res.sample_valid    = s_valid;
		res.sample_value    = s_value;
		res.sample_is_float = s_float;
		res.run_done        = done;
		res.status          = stat;
	end

	assign res_load = step && (s_valid || done);

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			fcnt_q  <= 4'd0;
			brem_q  <= 32'd0;
			tag_q   <= 32'd0;
			clen_q  <= 32'd0;
			fmt_q   <= 1'b0;
			chans_q <= 16'd1;
			bits_q  <= 16'd16;
			fpos_q  <= 18'd0;
			asm_q   <= 32'd0;
		end else if (step) begin
			phase_q <= phase_d;
			fcnt_q  <= fcnt_d;
			brem_q  <= brem_d;
			tag_q   <= tag_d;
			clen_q  <= clen_d;
			fmt_q   <= fmt_d;
			chans_q <= chans_d;
			bits_q  <= bits_d;
			fpos_q  <= fpos_d;
			asm_q   <= asm_d;
		end
	end

endmodule

[hw/rtl/wse_out_reg.sv]
// ----------------------------------------------------------------------------
// wse_out_reg: result register
// Holds one result request until the sink takes it; frees itself in the
// same cycle that the held request is taken.
// ----------------------------------------------------------------------------
module wse_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_load,
	input  wse_pkg::step_res_t  res,
	output logic                res_ready,
	output logic                result_valid,
	input  logic                result_stall,
	output logic                sample_valid,
	output logic signed [31:0]  sample_value,
	output logic                sample_is_float,
	output logic                run_done,
	output logic [2:0]          status
);
	import wse_pkg::*;

	logic       valid_q;
	step_res_t  res_q;

	// free when empty or when the held request leaves this cycle
	assign res_ready = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_load) begin
			res_q <= res;
		end
	end

	assign result_valid    = valid_q;
	assign sample_valid    = res_q.sample_valid;
	assign sample_value    = signed'(res_q.sample_value);
	assign sample_is_float = res_q.sample_is_float;
	assign run_done        = res_q.run_done;
	assign status          = res_q.status;

endmodule

[hw/rtl/wav_stream_sample_extractor.sv]
// ----------------------------------------------------------------------------
// wav_stream_sample_extractor: RIFF/WAVE byte stream to first-channel samples
// Walks the chunks of a WAV file one byte at a time, captures channel count
// and bit depth from the fmt chunk and emits channel 0 of each whole frame of
// the data chunk, ending every file's run with a status.
//
//   channel   valid / stall               payload
//   input     byte_valid / byte_stall     in_byte, end_of_file
//   result    result_valid / result_stall sample_valid, sample_value,
//                                         sample_is_float, run_done, status
//
// One byte is taken every cycle that byte_stall is low; a byte's result goes
// from the input register through one parse pass into the result register.
// Most bytes give no result; at most one result per byte.
// arst_n clears the parse state to "expecting RIFF tag" and empties both
// registers. A stalled result register holds the byte in the input register
// and raises byte_stall; a new byte is still taken while a finished result
// waits, as long as the sink takes it in that cycle.
// ----------------------------------------------------------------------------
module wav_stream_sample_extractor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         in_byte,
	input  logic               end_of_file,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               sample_valid,
	output logic signed [31:0] sample_value,
	output logic               sample_is_float,
	output logic               run_done,
	output logic [2:0]         status
);
	import wse_pkg::*;

	logic       res_ready;
	logic       res_load;
	step_res_t  res;

	// chunk walker with its input register
	wse_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.in_byte    (in_byte),
		.end_of_file(end_of_file),
		.res_ready  (res_ready),
		.res_load   (res_load),
		.res        (res)
	);

	// result register
	wse_out_reg u_out_reg (
		.clk            (clk),
		.arst_n         (arst_n),
		.res_load       (res_load),
		.res            (res),
		.res_ready      (res_ready),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.sample_valid   (sample_valid),
		.sample_value   (sample_value),
		.sample_is_float(sample_is_float),
		.run_done       (run_done),
		.status         (status)
	);

endmodule

[tb/wse_stream_checker.sv]
// ----------------------------------------------------------------------------
// wse_stream_checker: result predictor and scoreboard for the WAV extractor
// Runs every accepted byte request through a cycle-free model of the parser,
// queues the result each byte should cause and compares every accepted result
// request with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module wse_stream_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               byte_stall,
	input  logic [7:0]         in_byte,
	input  logic               end_of_file,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic               sample_valid,
	input  logic signed [31:0] sample_value,
	input  logic               sample_is_float,
	input  logic               run_done,
	input  logic [2:0]         status,
	output int                 fail_count,
	output int                 pending_count,
	output int                 results_seen,
	output int                 samples_seen
);
	import wse_pkg::*;

	// Where the parser stands in the file
	typedef enum logic [2:0] {
		WP_RIFF_TAG,
		WP_RIFF_SIZE,
		WP_WAVE_TAG,
		WP_CHUNK_HDR,
		WP_FMT_BODY,
		WP_SKIP_BODY,
		WP_DATA_BODY,
		WP_FINISHED
	} wav_phase_t;

	// Model state
	wav_phase_t  ph;
	logic [3:0]  cnt;
	logic [31:0] left;
	logic [31:0] tag_sr;
	logic [31:0] chunk_len;
	logic        have_fmt;
	logic [15:0] n_chans;
	logic [15:0] bits_per;
	logic [17:0] frame_idx;
	logic [31:0] word_sr;

	// Run end raised by the byte being parsed
	logic        end_flag;
	logic [2:0]  end_code;

	// Results due from the block, oldest first
	step_res_t   due_results[$];
	step_res_t   want;
	step_res_t   seen;
	step_res_t   next_res;
	bit          bad;

	function automatic void reset_state();
		ph        = WP_RIFF_TAG;
		cnt       = '0;
		left      = '0;
		tag_sr    = '0;
		chunk_len = '0;
		have_fmt  = 1'b0;
		n_chans   = 16'd1;
		bits_per  = 16'd16;
		frame_idx = '0;
		word_sr   = '0;
	endfunction

	function automatic void close_run(input logic [2:0] code);
		ph       = WP_FINISHED;
		end_flag = 1'b1;
		end_code = code;
	endfunction

	// Parse one byte; returns 1 when it gives a result
	function automatic bit parse_byte(input logic [7:0] b, input logic last,
			output step_res_t r);
		wav_phase_t  was;
		bit          got_sample;
		bit          is_flt;
		logic [31:0] word;
		logic [31:0] off;
		logic [31:0] sbytes;
		logic [31:0] fbytes;
		was        = ph;
		got_sample = 1'b0;
		is_flt     = 1'b0;
		word       = '0;
		end_flag   = 1'b0;
		end_code   = ST_OK;
		case (ph)
			WP_RIFF_TAG, WP_WAVE_TAG: begin
				tag_sr = {tag_sr[23:0], b};
				cnt    = cnt + 4'd1;
				if (cnt == 4'd4) begin
					cnt = '0;
					if (ph == WP_RIFF_TAG) begin
						if (tag_sr == TAG_RIFF) ph = WP_RIFF_SIZE;
						else close_run(ST_BAD_RIFF);
					end else begin
						if (tag_sr == TAG_WAVE) ph = WP_CHUNK_HDR;
						else close_run(ST_BAD_WAVE);
					end
				end
			end
			WP_RIFF_SIZE: begin
				cnt = cnt + 4'd1;
				if (cnt == 4'd4) begin
					cnt = '0;
					ph  = WP_WAVE_TAG;
				end
			end
			WP_CHUNK_HDR: begin
				// tag is big-endian, length little-endian
				if (cnt < 4'd4) tag_sr = {tag_sr[23:0], b};
				else chunk_len = {b, chunk_len[31:8]};
				cnt = cnt + 4'd1;
				if (cnt == 4'd8) begin
					cnt = '0;
					if (tag_sr == TAG_FMT) begin
						have_fmt = 1'b1;
						left     = chunk_len;
						if (chunk_len == 0) ph = WP_CHUNK_HDR;
						else ph = WP_FMT_BODY;
					end else if (tag_sr == TAG_DATA) begin
						if (!have_fmt) close_run(ST_NO_FMT);
						else if (bits_per != 16'd16 && bits_per != 16'd24 &&
								bits_per != 16'd32) close_run(ST_BAD_DEPTH);
						else if (n_chans == 16'd0) close_run(ST_ZERO_CHANS);
						else begin
							left      = chunk_len;
							frame_idx = '0;
							word_sr   = '0;
							if (chunk_len == 0) close_run(ST_OK);
							else ph = WP_DATA_BODY;
						end
					end else begin
						// unknown chunk: body plus pad byte when odd
						left = chunk_len;
						cnt  = {3'd0, chunk_len[0]};
						if (chunk_len == 0 && cnt == 4'd0) ph = WP_CHUNK_HDR;
						else ph = WP_SKIP_BODY;
					end
				end
			end
			WP_FMT_BODY: begin
				off    = chunk_len - left;
				tag_sr = {b, tag_sr[31:8]};
				if (off == 32'd3) n_chans = tag_sr[31:16];
				else if (off == 32'd15) bits_per = tag_sr[31:16];
				left = left - 32'd1;
				if (off >= 32'd15 && left > 0) begin
					cnt = {3'd0, chunk_len[0]};
					ph  = WP_SKIP_BODY;
				end else if (left == 0) begin
					cnt = {3'd0, chunk_len[0]};
					if (cnt != 4'd0) ph = WP_SKIP_BODY;
					else ph = WP_CHUNK_HDR;
				end
			end
			WP_SKIP_BODY: begin
				if (left > 0) left = left - 32'd1;
				else cnt = '0;
				if (left == 0 && cnt == 4'd0) ph = WP_CHUNK_HDR;
			end
			WP_DATA_BODY: begin
				sbytes = {19'd0, bits_per[15:3]};
				fbytes = {16'd0, n_chans} * sbytes;
				left   = left - 32'd1;
				if ({14'd0, frame_idx} < sbytes) begin
					word_sr = {b, word_sr[31:8]};
					// emit only when the whole frame fits in the chunk
					if ({14'd0, frame_idx} == sbytes - 32'd1 &&
							left >= fbytes - sbytes) begin
						got_sample = 1'b1;
						if (sbytes == 32'd4) begin
							word   = word_sr;
							is_flt = 1'b1;
						end else begin
							if (sbytes == 32'd2) word = {8'd0, word_sr[31:16], 8'd0};
							else word = {8'd0, word_sr[31:8]};
							if (word[23]) word[31:24] = 8'hFF;
						end
					end
				end
				frame_idx = frame_idx + 18'd1;
				if ({14'd0, frame_idx} >= fbytes) frame_idx = '0;
				if (left == 0) close_run(ST_OK);
			end
			default: ;
		endcase

		// last byte of the file: close an open run, then rearm
		if (last) begin
			if (!end_flag && was != WP_FINISHED) begin
				case (ph)
					WP_RIFF_TAG, WP_RIFF_SIZE: close_run(ST_BAD_RIFF);
					WP_WAVE_TAG:               close_run(ST_BAD_WAVE);
					WP_DATA_BODY:              close_run(ST_TRUNCATED);
					default:                   close_run(ST_NO_DATA);
				endcase
			end
			reset_state();
		end

		r.sample_valid    = got_sample;
		r.sample_value    = got_sample ? word : 32'd0;
		r.sample_is_float = got_sample ? is_flt : 1'b0;
		r.run_done        = end_flag;
		r.status          = end_flag ? end_code : ST_OK;
		return got_sample || end_flag;
	endfunction

	// Scoreboard: result requests first, then the byte request of this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_state();
			due_results.delete();
			fail_count    = 0;
			pending_count = 0;
			results_seen  = 0;
			samples_seen  = 0;
		end else begin
			if (result_valid && !result_stall) begin
				seen.sample_valid    = sample_valid;
				seen.sample_value    = sample_value;
				seen.sample_is_float = sample_is_float;
				seen.run_done        = run_done;
				seen.status          = status;
				results_seen++;
				if (sample_valid) samples_seen++;
				if (due_results.size() == 0) begin
					$display("%0t unexpected result: valid %b value %h float %b done %b status %0d",
						$time, seen.sample_valid, seen.sample_value, seen.sample_is_float,
						seen.run_done, seen.status);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					bad  = 1'b0;
					if (seen.sample_valid !== want.sample_valid) begin
						$display("%0t sample_valid: expected %b, got %b",
							$time, want.sample_valid, seen.sample_valid);
						bad = 1'b1;
					end
					if (seen.sample_value !== want.sample_value) begin
						$display("%0t sample_value: expected %h, got %h",
							$time, want.sample_value, seen.sample_value);
						bad = 1'b1;
					end
					if (seen.sample_is_float !== want.sample_is_float) begin
						$display("%0t sample_is_float: expected %b, got %b",
							$time, want.sample_is_float, seen.sample_is_float);
						bad = 1'b1;
					end
					if (seen.run_done !== want.run_done) begin
						$display("%0t run_done: expected %b, got %b",
							$time, want.run_done, seen.run_done);
						bad = 1'b1;
					end
					if (seen.status !== want.status) begin
						$display("%0t status: expected %0d, got %0d",
							$time, want.status, seen.status);
						bad = 1'b1;
					end
					if (bad) fail_count++;
				end
			end
			if (byte_valid && !byte_stall) begin
				if (parse_byte(in_byte, end_of_file, next_res)) due_results.push_back(next_res);
			end
			pending_count = due_results.size();
		end
	end

endmodule

[tb/tb_wav_stream_sample_extractor.sv]
// ----------------------------------------------------------------------------
// tb_wav_stream_sample_extractor: stimulus and verdict for the WAV extractor
// Feeds whole WAV files byte by byte: a directed set covering every status
// and corner of the chunk walk, then random well-formed, damaged and noise
// files, with random gaps on the byte side and random stalls on the result
// side. Checking is done by the scoreboard beside the block.
// ----------------------------------------------------------------------------
module tb_wav_stream_sample_extractor;
	import wse_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               byte_valid;
	logic               byte_stall;
	logic [7:0]         in_byte;
	logic               end_of_file;
	logic               result_valid;
	logic               result_stall;
	logic               sample_valid;
	logic signed [31:0] sample_value;
	logic               sample_is_float;
	logic               run_done;
	logic [2:0]         status;

	int                 fail_count;
	int                 pending_count;
	int                 results_seen;
	int                 samples_seen;
	int                 bytes_sent;
	int                 files_sent;
	bit                 pressure_done;
	bit                 gapless;
	logic [7:0]         file_q[$];

	wav_stream_sample_extractor u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.in_byte         (in_byte),
		.end_of_file     (end_of_file),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.sample_valid    (sample_valid),
		.sample_value    (sample_value),
		.sample_is_float (sample_is_float),
		.run_done        (run_done),
		.status          (status)
	);

	wse_stream_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.in_byte         (in_byte),
		.end_of_file     (end_of_file),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.sample_valid    (sample_valid),
		.sample_value    (sample_value),
		.sample_is_float (sample_is_float),
		.run_done        (run_done),
		.status          (status),
		.fail_count      (fail_count),
		.pending_count   (pending_count),
		.results_seen    (results_seen),
		.samples_seen    (samples_seen)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

	// Gap before a byte request: mostly none, a few long
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (gapless || k < 55) return 0;
		if (k < 85) return $urandom_range(1, 3);
		if (k < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// One byte request; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid  <= 1'b1;
		in_byte     <= b;
		end_of_file <= last;
		do @(posedge clk); while (byte_stall);
		@(negedge clk);
	endtask

	// File building, bytes in file order
	task automatic push_le(input logic [31:0] v, input int n);
		int i;
		for (i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
	endtask

	task automatic push_tag(input logic [31:0] tag);
		int i;
		for (i = 3; i >= 0; i--) file_q.push_back(tag[8*i +: 8]);
	endtask

	task automatic push_rand(input int n);
		int i;
		for (i = 0; i < n; i++) file_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic push_head();
		push_tag(TAG_RIFF);
		push_le($urandom, 4);
		push_tag(TAG_WAVE);
	endtask

	task automatic push_chunk(input logic [31:0] tag, input int len);
		push_tag(tag);
		push_le(len, 4);
		push_rand(len);
		if (len % 2) file_q.push_back(8'h00);
	endtask

	task automatic push_data(input int len);
		push_tag(TAG_DATA);
		push_le(len, 4);
	endtask

	// fmt chunk of any length; a short one carries only its leading fields
	task automatic push_fmt(input logic [15:0] chans, input logic [15:0] depth,
			input int len);
		logic [7:0] body [16];
		int         i;
		body[0] = 8'h01;
		body[1] = 8'h00;
		body[2] = chans[7:0];
		body[3] = chans[15:8];
		for (i = 4; i < 14; i++) body[i] = 8'($urandom_range(0, 255));
		body[14] = depth[7:0];
		body[15] = depth[15:8];
		push_tag(TAG_FMT);
		push_le(len, 4);
		for (i = 0; i < len; i++) begin
			if (i < 16) file_q.push_back(body[i]);
			else file_q.push_back(8'($urandom_range(0, 255)));
		end
		if (len % 2) file_q.push_back(8'h00);
	endtask

	// Send the built file, end_of_file on its last byte
	task automatic send_file();
		int i;
		gapless = ($urandom_range(0, 3) == 0);
		for (i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
		bytes_sent += file_q.size();
		files_sent++;
		file_q.delete();
	endtask

	task automatic run_directed();
		// bad RIFF tag; its last byte also ends the file
		push_tag(32'h5249_4658);
		send_file();
		// file ends inside the RIFF tag, then inside the RIFF size
		push_le(32'h0000_4952, 2);
		send_file();
		push_tag(TAG_RIFF);
		push_le(32'hFFFF_FFFF, 2);
		send_file();
		// bad WAVE tag, then bytes ignored until end of file
		push_tag(TAG_RIFF);
		push_le(32'h0, 4);
		push_tag(32'h5741_5658);
		push_rand(3);
		send_file();
		// file ends inside the WAVE tag
		push_tag(TAG_RIFF);
		push_le(32'h1234_5678, 4);
		push_le(32'h0000_4157, 2);
		send_file();
		// data chunk before any fmt chunk
		push_head();
		push_data(4);
		push_rand(4);
		send_file();
		// unsupported depth, then zero channels
		push_head();
		push_fmt(16'd1, 16'd8, 16);
		push_data(2);
		push_rand(2);
		send_file();
		push_head();
		push_fmt(16'd0, 16'd16, 16);
		push_data(2);
		push_rand(2);
		send_file();
		// empty data chunk closes the run at its header
		push_head();
		push_fmt(16'd1, 16'd16, 16);
		push_data(0);
		push_rand(2);
		send_file();
		// odd and empty unknown chunks; 16-bit extremes and a partial frame
		push_head();
		push_chunk(32'h4C49_5354, 3);
		push_chunk(32'h4A55_4E4B, 0);
		push_fmt(16'd1, 16'd16, 16);
		push_data(9);
		push_le(32'h8000, 2);
		push_le(32'h7FFF, 2);
		push_le(32'h0000, 2);
		push_le(32'hFFFF, 2);
		push_rand(2);
		send_file();
		// 24-bit stereo extremes; the last frame is cut short
		push_head();
		push_fmt(16'd2, 16'd24, 16);
		push_data(16);
		push_le(32'h80_0000, 3);
		push_rand(3);
		push_le(32'h7F_FFFF, 3);
		push_rand(3);
		push_rand(4);
		send_file();
		// 32-bit float with a long fmt chunk; file ends on the last data byte
		push_head();
		push_fmt(16'd1, 16'd32, 18);
		push_data(8);
		push_le(32'hFFFF_FFFF, 4);
		push_le(32'h0000_0000, 4);
		send_file();
		// fmt chunks of length 0, 2 and 15 after a full one
		push_head();
		push_fmt(16'd3, 16'd24, 16);
		push_fmt(16'd5, 16'd16, 0);
		push_fmt(16'd7, 16'd16, 2);
		push_fmt(16'd1, 16'd99, 15);
		push_data(6);
		push_rand(6);
		send_file();
		// data chunk shorter than declared
		push_head();
		push_fmt(16'd1, 16'd16, 16);
		push_data(100);
		push_rand(5);
		send_file();
		// file ends while walking chunks, once mid-header, once at a boundary
		push_head();
		push_fmt(16'd2, 16'd16, 16);
		push_le(32'h0000_4C49, 2);
		send_file();
		push_head();
		send_file();
		// one-sample data chunk: sample and run end in one result
		push_head();
		push_fmt(16'd1, 16'd16, 16);
		push_data(2);
		push_rand(5);
		send_file();
	endtask

	// Random file: mostly well formed, some damaged, a few pure noise
	task automatic send_random_file();
		int          kind, k, i, n, sb, fb, len, flen, cut;
		logic [15:0] chans, depth;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			if (kind < 4) push_tag(TAG_RIFF);
			push_rand($urandom_range(1, 12));
		end else begin
			push_tag(($urandom_range(0, 99) < 4) ? $urandom : TAG_RIFF);
			push_le($urandom, 4);
			push_tag(($urandom_range(0, 99) < 4) ? $urandom : TAG_WAVE);
			n = $urandom_range(0, 2);
			for (i = 0; i < n; i++) push_chunk($urandom, $urandom_range(0, 7));
			k = $urandom_range(0, 99);
			if (k < 55) chans = 16'd1;
			else if (k < 80) chans = 16'd2;
			else if (k < 92) chans = 16'($urandom_range(3, 4));
			else chans = 16'($urandom_range(0, 65535));
			k = $urandom_range(0, 99);
			if (k < 30) depth = 16'd16;
			else if (k < 60) depth = 16'd24;
			else if (k < 90) depth = 16'd32;
			else if (k < 95) depth = 16'($urandom_range(0, 40));
			else depth = 16'($urandom_range(0, 65535));
			k = $urandom_range(0, 99);
			if (k < 85) flen = 16;
			else if (k < 95) flen = $urandom_range(17, 20);
			else flen = $urandom_range(0, 15);
			if ($urandom_range(0, 99) >= 5) push_fmt(chans, depth, flen);
			if ($urandom_range(0, 3) == 0) push_chunk($urandom, $urandom_range(0, 5));
			sb = int'(depth) / 8;
			fb = int'(chans) * sb;
			push_tag(TAG_DATA);
			if ($urandom_range(0, 99) < 5) begin
				// huge declared length; the file ends inside the body
				push_le($urandom, 4);
				push_rand($urandom_range(0, 20));
			end else begin
				if (chans <= 4 && fb > 0 && (depth == 16 || depth == 24 || depth == 32)) begin
					len = $urandom_range(1, 6) * fb;
					if ($urandom_range(0, 2) == 0) len += $urandom_range(0, fb - 1);
				end else begin
					len = $urandom_range(0, 12);
				end
				push_le(len, 4);
				push_rand(len);
				push_rand($urandom_range(0, 3));
			end
		end
		// now and then cut the file short
		if ($urandom_range(0, 99) < 6) begin
			cut = $urandom_range(1, file_q.size());
			while (file_q.size() > cut) void'(file_q.pop_back());
		end
		send_file();
	endtask

	// Result side: random stalls plus one long hold-off with results waiting
	initial begin
		int k;
		int run_len;
		bit hold;
		result_stall = 1'b0;
		run_len      = 0;
		hold         = 1'b0;
		forever begin
			@(negedge clk);
			if (!pressure_done && results_seen >= 3) begin
				result_stall <= 1'b1;
				repeat (150) @(negedge clk);
				pressure_done = 1'b1;
				run_len       = 0;
				result_stall <= 1'b0;
			end else begin
				if (run_len == 0) begin
					k = $urandom_range(0, 99);
					if (k < 55) begin
						hold    = 1'b0;
						run_len = $urandom_range(1, 12);
					end else if (k < 85) begin
						hold    = 1'b1;
						run_len = $urandom_range(1, 3);
					end else if (k < 95) begin
						hold    = 1'b0;
						run_len = $urandom_range(40, 120);
					end else begin
						hold    = 1'b1;
						run_len = $urandom_range(10, 40);
					end
				end
				result_stall <= hold;
				run_len--;
			end
		end
	end

	// Reset, stimulus, drain and verdict
	initial begin
		int dir_bytes;
		arst_n        = 1'b0;
		byte_valid    = 1'b0;
		in_byte       = 8'h00;
		end_of_file   = 1'b0;
		bytes_sent    = 0;
		files_sent    = 0;
		gapless       = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		dir_bytes = bytes_sent;
		while (bytes_sent - dir_bytes < 100) send_random_file();
		byte_valid <= 1'b0;

		while (pending_count != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (pending_count != 0) $display("%0t %0d results never arrived", $time, pending_count);

		$display("Sent %0d files (%0d bytes): %0d results checked, %0d carrying samples.",
			files_sent, bytes_sent, results_seen, samples_seen);
		$display("Every run status, all depths and one long result hold-off were exercised.");
		if (fail_count == 0 && pending_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
